// ===== rtl/atc_pkg.sv =====
// Shared types, constants, a lookup function and a conversion step function for the access token checker.
`timescale 1ns / 1ps
`default_nettype none

package atc_pkg;

  // Field widths
  localparam int unsigned PASSWORD_W = 27;
  localparam int unsigned NOW_W      = 25;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned VISIT_W    = 20;
  localparam int unsigned KEY_W      = 6;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned CFG_IDX_W  = 1;

  // Binary to BCD conversion geometry
  localparam int unsigned NUM_DIGITS = 8;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned DD_STEPS   = 7;
  localparam int unsigned DD_STAGES  = (PASSWORD_W + DD_STEPS - 1) / DD_STEPS;

  // Limits
  localparam logic [PASSWORD_W-1:0] MAX_CODE = PASSWORD_W'(99999999);
  localparam int unsigned           MAX_TIME_UNITS = 52704;
  localparam int unsigned           WINDOW_SECONDS = 1 * 60 * 60;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_OFFSET   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_DIGIT = 1'd1;

  // Verdict codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_TIME_CHK  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_DEV_CHK   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_WINDOW    = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 3'd5;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic [PASSWORD_W-1:0] password;
    logic [NOW_W-1:0]      now_seconds;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VISIT_W-1:0]  visit_minutes;
  } res_t;

  // Digit descramble ROM: row picked by the lead digit
  localparam digit_t PERM_ROM [10][10] = '{
    '{4'd9, 4'd0, 4'd5, 4'd1, 4'd6, 4'd2, 4'd7, 4'd3, 4'd8, 4'd4},
    '{4'd5, 4'd0, 4'd9, 4'd1, 4'd8, 4'd2, 4'd7, 4'd3, 4'd6, 4'd4},
    '{4'd4, 4'd5, 4'd0, 4'd6, 4'd1, 4'd7, 4'd2, 4'd8, 4'd3, 4'd9},
    '{4'd4, 4'd9, 4'd0, 4'd8, 4'd1, 4'd7, 4'd2, 4'd6, 4'd3, 4'd5},
    '{4'd9, 4'd4, 4'd5, 4'd3, 4'd6, 4'd2, 4'd7, 4'd1, 4'd8, 4'd0},
    '{4'd5, 4'd4, 4'd9, 4'd3, 4'd8, 4'd2, 4'd7, 4'd1, 4'd6, 4'd0},
    '{4'd0, 4'd5, 4'd4, 4'd6, 4'd3, 4'd7, 4'd2, 4'd8, 4'd1, 4'd9},
    '{4'd0, 4'd9, 4'd4, 4'd8, 4'd3, 4'd7, 4'd2, 4'd6, 4'd1, 4'd5},
    '{4'd6, 4'd3, 4'd8, 4'd4, 4'd9, 4'd2, 4'd7, 4'd0, 4'd5, 4'd1},
    '{4'd1, 4'd8, 4'd3, 4'd9, 4'd4, 4'd7, 4'd2, 4'd5, 4'd0, 4'd6}
  };

  // ROM read; non-decimal codes read as zero
  function automatic digit_t perm_digit(input digit_t row, input digit_t col);
    digit_t res;
    res = '0;
    if (row <= 4'd9 && col <= 4'd9) begin
      res = PERM_ROM[row][col];
    end
    return res;
  endfunction

  // One double-dabble step: add 3 to digits of five or more, shift in one bit
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic bin_bit);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (adj[DIGIT_W*i +: DIGIT_W] >= 4'd5) begin
        adj[DIGIT_W*i +: DIGIT_W] = adj[DIGIT_W*i +: DIGIT_W] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bin_bit};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/atc_bcd_pipe.sv =====
// Pipelined binary to BCD converter with a side channel carried alongside.
`timescale 1ns / 1ps
`default_nettype none

module atc_bcd_pipe #(
  parameter int unsigned SideW = 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire logic [atc_pkg::PASSWORD_W-1:0] bin_i,
  input  wire logic [SideW-1:0]               side_i,
  output logic                                valid_o,
  output logic [atc_pkg::BCD_W-1:0]           bcd_o,
  output logic [SideW-1:0]                    side_o
);

  localparam int unsigned NumStages = atc_pkg::DD_STAGES;
  localparam int unsigned Steps     = atc_pkg::DD_STEPS;
  localparam int unsigned BinW      = atc_pkg::PASSWORD_W;
  localparam int unsigned BcdW      = atc_pkg::BCD_W;

  logic              vld_q  [NumStages];
  logic [BcdW-1:0]   bcd_q  [NumStages];
  logic [BinW-1:0]   bin_q  [NumStages];
  logic [SideW-1:0]  side_q [NumStages];

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic             vld_in;
    logic [BcdW-1:0]  bcd_in;
    logic [BinW-1:0]  bin_in;
    logic [SideW-1:0] side_in;
    logic [BcdW-1:0]  bcd_d;
    logic [BinW-1:0]  bin_d;

    // Stage input: ports for the first stage, previous stage otherwise
    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign bcd_in  = '0;
      assign bin_in  = bin_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign bcd_in  = bcd_q[s-1];
      assign bin_in  = bin_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Up to Steps shift/adjust steps, MSB first
    always_comb begin
      bcd_d = bcd_in;
      bin_d = bin_in;
      for (int j = 0; j < Steps; j++) begin
        if (s * Steps + j < BinW) begin
          bcd_d = atc_pkg::dd_step(bcd_d, bin_d[BinW-1]);
          bin_d = {bin_d[BinW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      bcd_q[s]  <= bcd_d;
      bin_q[s]  <= bin_d;
      side_q[s] <= side_in;
    end
  end

  assign valid_o = vld_q[NumStages-1];
  assign bcd_o   = bcd_q[NumStages-1];
  assign side_o  = side_q[NumStages-1];

endmodule

`default_nettype wire

// ===== rtl/access_token_checker_core.sv =====
// Top level of the access token checker: decode, time checks and verdict.
//
//  Port group        Direction  Transfer
//  start_i/req_i     in         code and current time, taken when start_i & !busy_o
//  done_o/res_o      out        one verdict per code, one cycle wide, no hold-off
//  cfg_we_i/idx/data in         register write, taken when cfg_we_i is high
//
// A code enters in every cycle; busy_o stays low. Each verdict passes through
// the BCD conversion stages (7 shift steps per stage over 27 bits), then the
// descramble, time decode, check and output registers. Reset clears the valid
// bits and the configuration registers. The receiver takes every verdict in its
// cycle, so the pipeline never stalls.
`timescale 1ns / 1ps
`default_nettype none

module access_token_checker_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire atc_pkg::req_t                  req_i,
  output logic                                done_o,
  output atc_pkg::res_t                       res_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [atc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [atc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned NowW  = atc_pkg::NOW_W;
  localparam int unsigned SideW = NowW + 1;
  localparam int unsigned DigW  = atc_pkg::DIGIT_W;

  // Configuration registers
  logic [atc_pkg::KEY_W-1:0] key_offset_q;
  atc_pkg::digit_t           device_digit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_offset_q   <= '0;
      device_digit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        atc_pkg::CFG_KEY_OFFSET:   key_offset_q   <= cfg_wdata_i[atc_pkg::KEY_W-1:0];
        atc_pkg::CFG_DEVICE_DIGIT: device_digit_q <= cfg_wdata_i[DigW-1:0];
        default: ;
      endcase
    end
  end

  // Always ready: one code per cycle
  assign busy_o = 1'b0;

  logic accept;
  logic malformed;
  assign accept    = start_i & ~busy_o;
  assign malformed = req_i.password > atc_pkg::MAX_CODE;

  // BCD conversion stages
  logic                      cv_vld;
  logic [atc_pkg::BCD_W-1:0] cv_bcd;
  logic [SideW-1:0]          cv_side;

  atc_bcd_pipe #(
    .SideW (SideW)
  ) u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .bin_i   (req_i.password),
    .side_i  ({malformed, req_i.now_seconds}),
    .valid_o (cv_vld),
    .bcd_o   (cv_bcd),
    .side_o  (cv_side)
  );

  // Stage A: descramble digits 1..7 with the row chosen by the lead digit
  atc_pkg::digit_t pd_d [1:7];
  atc_pkg::digit_t lead;
  assign lead = cv_bcd[DigW*7 +: DigW];

  always_comb begin
    for (int i = 1; i < 8; i++) begin
      pd_d[i] = atc_pkg::perm_digit(lead, cv_bcd[DigW*(7-i) +: DigW]);
    end
  end

  logic            a_vld_q;
  atc_pkg::digit_t a_pd_q [1:7];
  atc_pkg::digit_t a_lead_q;
  logic [NowW-1:0] a_now_q;
  logic            a_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= cv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    a_pd_q   <= pd_d;
    a_lead_q <= lead;
    a_now_q  <= cv_side[NowW-1:0];
    a_bad_q  <= cv_side[NowW];
  end

  // Stage B: time units minus key offset, in binary and in BCD
  logic [16:0]        units;
  logic signed [17:0] t_d;
  logic [9:0]         key_x13;
  atc_pkg::digit_t    key_dig [5];
  atc_pkg::digit_t    u_dig   [5];
  atc_pkg::digit_t    t_dig_d [5];
  logic [4:0]         sub;
  logic               borrow;

  always_comb begin
    units = 17'(a_pd_q[1]) * 17'd10000 + 17'(a_pd_q[2]) * 17'd1000
          + 17'(a_pd_q[3]) * 17'd100 + 17'(a_pd_q[4]) * 17'd10
          + 17'(a_pd_q[5]);
    t_d = $signed({1'b0, units}) - $signed(18'(key_offset_q));

    // Offset tens digit by reciprocal multiply, exact for offsets below 64
    key_x13    = 10'(key_offset_q) * 10'd13;
    key_dig[1] = DigW'(key_x13[9:7]);
    key_dig[0] = DigW'(key_offset_q - 6'(key_dig[1]) * 6'd10);
    key_dig[2] = '0;
    key_dig[3] = '0;
    key_dig[4] = '0;

    // Digit-wise subtract with borrow, ones digit first
    for (int i = 0; i < 5; i++) begin
      u_dig[i] = a_pd_q[5-i];
    end
    borrow = 1'b0;
    for (int i = 0; i < 5; i++) begin
      sub = {1'b0, u_dig[i]} - {1'b0, key_dig[i]} - 5'(borrow);
      if (sub[4]) begin
        t_dig_d[i] = sub[3:0] + 4'd10;
        borrow     = 1'b1;
      end else begin
        t_dig_d[i] = sub[3:0];
        borrow     = 1'b0;
      end
    end
  end

  logic               b_vld_q;
  logic signed [17:0] b_t_q;
  atc_pkg::digit_t    b_t_dig_q [5];
  atc_pkg::digit_t    b_lead_q;
  atc_pkg::digit_t    b_pd6_q;
  atc_pkg::digit_t    b_pd7_q;
  logic [NowW-1:0]    b_now_q;
  logic               b_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_t_q     <= t_d;
    b_t_dig_q <= t_dig_d;
    b_lead_q  <= a_lead_q;
    b_pd6_q   <= a_pd_q[6];
    b_pd7_q   <= a_pd_q[7];
    b_now_q   <= a_now_q;
    b_bad_q   <= a_bad_q;
  end

  // Stage C: range check, minutes, seconds and both check digits
  logic                         range_bad;
  logic [atc_pkg::VISIT_W-1:0]  visit_d;
  logic [NowW-1:0]              secs_d;
  atc_pkg::digit_t              chk;
  atc_pkg::digit_t              chk_mod;

  always_comb begin
    range_bad = b_t_q[17] || (b_t_q > 18'(atc_pkg::MAX_TIME_UNITS));
    visit_d   = 20'(b_t_q[15:0]) * 20'd10;
    secs_d    = 25'(b_t_q[15:0]) * 25'd600;
    chk = b_lead_q;
    for (int i = 0; i < 5; i++) begin
      chk = chk ^ b_t_dig_q[i];
    end
    chk_mod = (chk >= 4'd10) ? chk - 4'd10 : chk;
  end

  logic                        c_vld_q;
  logic                        c_range_bad_q;
  logic                        c_chk_ok_q;
  logic                        c_dev_ok_q;
  logic [atc_pkg::VISIT_W-1:0] c_visit_q;
  logic [NowW-1:0]             c_secs_q;
  logic [NowW-1:0]             c_now_q;
  logic                        c_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_range_bad_q <= range_bad;
    c_chk_ok_q    <= (chk_mod == b_pd6_q);
    c_dev_ok_q    <= (device_digit_q == b_pd7_q);
    c_visit_q     <= visit_d;
    c_secs_q      <= secs_d;
    c_now_q       <= b_now_q;
    c_bad_q       <= b_bad_q;
  end

  // Stage D: one-hour window and verdict
  logic signed [NowW:0] diff;
  logic                 outside;
  atc_pkg::res_t        res_d;

  always_comb begin
    diff    = $signed({1'b0, c_now_q}) - $signed({1'b0, c_secs_q});
    outside = (diff > $signed((NowW+1)'(atc_pkg::WINDOW_SECONDS)))
           || (diff < -$signed((NowW+1)'(atc_pkg::WINDOW_SECONDS)));
    res_d.visit_minutes = c_visit_q;
    if (c_bad_q) begin
      res_d.status        = atc_pkg::STATUS_MALFORMED;
      res_d.visit_minutes = '0;
    end else if (c_range_bad_q) begin
      res_d.status        = atc_pkg::STATUS_RANGE;
      res_d.visit_minutes = '0;
    end else if (!c_chk_ok_q) begin
      res_d.status = atc_pkg::STATUS_TIME_CHK;
    end else if (!c_dev_ok_q) begin
      res_d.status = atc_pkg::STATUS_DEV_CHK;
    end else if (outside) begin
      res_d.status = atc_pkg::STATUS_WINDOW;
    end else begin
      res_d.status = atc_pkg::STATUS_OK;
    end
  end

  logic          done_q;
  atc_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire
